// File: rtl/bfm_pkg.sv
// Package for the buffer frame manager: sizes, codes and state machine type.
package bfm_pkg;
  localparam int Frames   = 16;
  localparam int FrameW   = 4;
  localparam int CountW   = 5;
  localparam int PinW     = 8;
  localparam int PageW    = 32;
  localparam int ScanW    = 6;
  localparam logic [PinW-1:0] PinMax = 8'd255;

  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POOL_FULL = 2'd1,
    ST_NOT_RES   = 2'd2,
    ST_PIN_ERR   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DONE
  } state_t;
endpackage

// File: rtl/buffer_frame_manager_second_chance.sv
// Buffer frame manager with second-chance replacement.
// Flow: a hit, release or free-stack miss goes from accept through the look-up
//   and finishing states to result valid; a miss with no free frame first scans
//   the FIFO for a victim, at most 2*fifo_count = 32 pops, each a read and a check.
// One transaction at a time; the next is accepted the cycle after the result leaves.
// Reset: synchronous, active low; clears all marks and pin counts, the FIFO, free and
//   pinned counters, the free stack to frames 0..15 and the result valid flag. Page ids are left undefined.
module buffer_frame_manager_second_chance import bfm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_action,
  input  logic [31:0]      in_page_id,
  input  logic             in_dirty,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_status,
  output logic [3:0]       out_frame,
  output logic             out_hit,
  output logic             out_writeback_valid,
  output logic [31:0]      out_writeback_page,
  output logic             out_fill_valid,
  output logic [4:0]       out_pinned_frames
);

  // Page id memory (one write, one read port) and FIFO memory
  logic [PageW-1:0]  page_mem [Frames];
  logic [FrameW-1:0] fifo_mem [Frames];
  logic [PageW-1:0]  page_rd_r;
  logic [FrameW-1:0] fifo_rd_r;

  // Per-frame flags and counts in flops (lookup compares all frames)
  logic [Frames-1:0]     valid_r, dirty_r, ref_r, queued_r;
  logic [PinW-1:0]       pin_r [Frames];
  logic [PageW-1:0]      tag_r [Frames];
  logic [FrameW-1:0]     free_r [Frames];
  logic [CountW-1:0]     free_top_r, fifo_cnt_r, pinned_r;
  logic [FrameW-1:0]     head_r, tail_r;
  logic [ScanW-1:0]      scan_left_r;

  state_t state_r, state_nxt;
  logic             act_r, dirty_in_r;
  logic [PageW-1:0] pid_r;
  logic             found_r;
  logic [FrameW-1:0] hit_f_r, vic_r;

  // Lookup across all tags
  logic             found;
  logic [FrameW-1:0] found_f;
  always_comb begin
    found = 1'b0;
    found_f = '0;
    for (int i = Frames-1; i >= 0; i--) begin
      if (valid_r[i] && tag_r[i] == pid_r) begin
        found = 1'b1;
        found_f = FrameW'(i);
      end
    end
  end

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state_r != S_IDLE) || out_valid;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_acc) state_nxt = S_LOOK;
      S_LOOK: begin
        if (act_r == ACT_REQUEST && !found && free_top_r == '0 &&
            fifo_cnt_r != '0)
          state_nxt = S_SCAN_RD;
        else
          state_nxt = S_DONE;
      end
      S_SCAN_RD:  state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (pin_r[fifo_rd_r] == '0 && !ref_r[fifo_rd_r])
          state_nxt = S_DONE;
        else if (scan_left_r == ScanW'(1) || fifo_cnt_r == CountW'(1) &&
                 pin_r[fifo_rd_r] != '0)
          state_nxt = S_DONE;
        else
          state_nxt = S_SCAN_RD;
      end
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  logic got_victim_r;
  logic popped_pinned, popped_ref;
  always_comb begin
    popped_pinned = (state_r == S_SCAN_CHK) && (pin_r[fifo_rd_r] != '0);
    popped_ref    = (state_r == S_SCAN_CHK) && !popped_pinned && ref_r[fifo_rd_r];
  end

  logic [FrameW-1:0] done_f;
  logic              done_miss_ok, done_free;
  always_comb begin
    done_free    = (free_top_r != '0);
    done_miss_ok = done_free || got_victim_r;
    done_f       = done_free ? free_r[free_top_r[FrameW-1:0] - FrameW'(1)] : vic_r;
  end

  // Build the result of the finishing step
  status_t           res_status;
  logic [FrameW-1:0] res_frame;
  logic              res_hit, res_wb, res_fill;
  logic [PageW-1:0]  res_wb_page;
  logic [CountW-1:0] pinned_nxt;
  always_comb begin
    res_status  = ST_OK;
    res_frame   = '0;
    res_hit     = 1'b0;
    res_wb      = 1'b0;
    res_wb_page = '0;
    res_fill    = 1'b0;
    pinned_nxt  = pinned_r;
    if (act_r == ACT_REQUEST) begin
      if (found_r) begin
        res_hit = 1'b1;
        if (pin_r[hit_f_r] >= PinMax) res_status = ST_PIN_ERR;
        else begin
          if (pin_r[hit_f_r] == '0) pinned_nxt = pinned_r + CountW'(1);
          res_frame = hit_f_r;
        end
      end else if (!done_miss_ok) begin
        res_status = ST_POOL_FULL;
      end else begin
        if (!done_free && valid_r[done_f] && dirty_r[done_f]) begin
          res_wb      = 1'b1;
          res_wb_page = page_rd_r;
        end
        pinned_nxt = pinned_r + CountW'(1);
        res_fill   = 1'b1;
        res_frame  = done_f;
      end
    end else begin
      if (!found_r) res_status = ST_NOT_RES;
      else if (pin_r[hit_f_r] == '0) res_status = ST_PIN_ERR;
      else begin
        if (pin_r[hit_f_r] == PinW'(1)) pinned_nxt = pinned_r - CountW'(1);
        res_frame = hit_f_r;
      end
    end
  end

  // Memory ports; the page read follows the popped frame so the victim's
  // page id is ready in the finishing step
  always_ff @(posedge clk) begin
    fifo_rd_r <= fifo_mem[head_r];
    page_rd_r <= page_mem[fifo_rd_r];
    if (state_r == S_SCAN_CHK && popped_ref)
      fifo_mem[tail_r] <= fifo_rd_r;
    else if (state_r == S_DONE && act_r == ACT_RELEASE && found_r &&
             pin_r[hit_f_r] == PinW'(1) && !queued_r[hit_f_r])
      fifo_mem[tail_r] <= hit_f_r;
    if (state_r == S_DONE && act_r == ACT_REQUEST && !found_r && done_miss_ok)
      page_mem[done_f] <= pid_r;
  end

  // Control and marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0; dirty_r <= '0; ref_r <= '0; queued_r <= '0;
      for (int i = 0; i < Frames; i++) begin
        pin_r[i]  <= '0;
        free_r[i] <= FrameW'(i);
      end
      free_top_r <= CountW'(Frames);
      fifo_cnt_r <= '0; pinned_r <= '0; head_r <= '0; tail_r <= '0;
      out_valid <= 1'b0;
      got_victim_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_acc) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_acc) begin
          act_r <= in_action; pid_r <= in_page_id; dirty_in_r <= in_dirty;
          got_victim_r <= 1'b0;
        end
        S_LOOK: begin
          found_r <= found; hit_f_r <= found_f;
          scan_left_r <= {fifo_cnt_r, 1'b0};
        end
        S_SCAN_RD: ;
        S_SCAN_CHK: begin
          // pop
          head_r <= head_r + FrameW'(1);
          scan_left_r <= scan_left_r - ScanW'(1);
          if (popped_pinned) begin
            queued_r[fifo_rd_r] <= 1'b0;
            fifo_cnt_r <= fifo_cnt_r - CountW'(1);
          end else if (popped_ref) begin
            ref_r[fifo_rd_r] <= 1'b0;
            tail_r <= tail_r + FrameW'(1);
          end else begin
            fifo_cnt_r <= fifo_cnt_r - CountW'(1);
            vic_r <= fifo_rd_r;
            got_victim_r <= 1'b1;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_status <= res_status; out_frame <= res_frame; out_hit <= res_hit;
          out_writeback_valid <= res_wb; out_writeback_page <= res_wb_page;
          out_fill_valid <= res_fill; out_pinned_frames <= pinned_nxt;
          pinned_r <= pinned_nxt;
          if (act_r == ACT_REQUEST) begin
            if (found_r) begin
              if (pin_r[hit_f_r] < PinMax) begin
                pin_r[hit_f_r] <= pin_r[hit_f_r] + PinW'(1);
                ref_r[hit_f_r] <= 1'b1;
              end
            end else if (done_miss_ok) begin
              if (done_free) free_top_r <= free_top_r - CountW'(1);
              valid_r[done_f] <= 1'b1; tag_r[done_f] <= pid_r;
              pin_r[done_f] <= PinW'(1); dirty_r[done_f] <= 1'b0;
              ref_r[done_f] <= 1'b1; queued_r[done_f] <= 1'b0;
            end
          end else if (found_r && pin_r[hit_f_r] != '0) begin
            pin_r[hit_f_r] <= pin_r[hit_f_r] - PinW'(1);
            if (pin_r[hit_f_r] == PinW'(1) && !queued_r[hit_f_r]) begin
              queued_r[hit_f_r] <= 1'b1;
              tail_r <= tail_r + FrameW'(1);
              fifo_cnt_r <= fifo_cnt_r + CountW'(1);
            end
            if (dirty_in_r) dirty_r[hit_f_r] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= CountW'(Frames)) else $error("fifo count overflow");
  a_pinned_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pinned_r <= CountW'(Frames)) else $error("pinned count overflow");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> state_r == S_IDLE && !out_valid) else $error("accept while busy");
  a_fill_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fill_valid |-> out_status == ST_OK && !out_hit)
    else $error("fill with bad status");
`endif
endmodule
